/* design/gti_pkg.sv */
`timescale 1ns / 1ps

package gti_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam int TIME_W  = 48;
    localparam int ANG_W   = 16;
    localparam int RATE_W  = 18;
    localparam int GAP_W   = 20;
    localparam int ALPHA_W = 17;
    localparam int ACC_W   = 20;
    localparam int LANES   = 6;

    localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [ALPHA_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic signed [ACC_W-1:0] HALF_TURN  = 20'sd18000;
    localparam logic signed [ACC_W-1:0] FULL_TURN  = 20'sd36000;
    localparam logic signed [ACC_W-1:0] TWO_TURNS  = 20'sd72000;
    localparam logic [4:0] DIV_STEPS = 5'd17;
    localparam logic [4:0] MUL_STEPS = 5'd6;
    localparam logic [GAP_W-1:0] MIN_GAP_RESET = 20'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FETCH2,
        ST_FETCH1,
        ST_CAP1,
        ST_GAP,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } gti_state_t;

    typedef enum logic [1:0] {
        OUT_EMPTY,
        OUT_SAMPLE,
        OUT_INTERP
    } gti_kind_t;

    // Map a logical index onto a ring slot.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] i);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, i};
        if (sum >= (CNT_W + 1)'(HISTORY_DEPTH))
            sum = sum - (CNT_W + 1)'(HISTORY_DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* design/gimbal_telemetry_time_interpolator_top.sv */
`timescale 1ns / 1ps

// Gimbal telemetry history with time interpolation. Pulse start with busy low
// to hand over one item: cmd 0 records a sample (taken in that cycle,
// busy stays low, out-of-order samples are dropped), cmd 1 queries the
// history at time_us. A query raises busy and returns exactly one result,
// shown for a single cycle with result_valid high; the receiver cannot stall
// it, so capture it on that cycle. A query runs a binary search in which each
// probe is one synchronous read of the time memory and one compare (at most
// ceil(log2(depth+1)) probes, 8 for 128 entries), fetches the two neighboring
// samples, checks the gap, runs the restoring divider that forms alpha and the
// one shared multiplier, and loads the result registers; the result is shown
// when busy is already low again; empty history and edge cases finish early.
// The min_gap_us register is written through cfg_valid/cfg_data, always ready.
module gimbal_telemetry_time_interpolator_top
    import gti_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [TIME_W-1:0]        time_us,
    input  logic [ANG_W-1:0]         pan_in,
    input  logic signed [ANG_W-1:0]  tilt_in,
    input  logic signed [ANG_W-1:0]  roll_in,
    input  logic signed [RATE_W-1:0] pan_rate_in,
    input  logic signed [RATE_W-1:0] tilt_rate_in,
    input  logic signed [RATE_W-1:0] roll_rate_in,
    input  logic                     leveled_in,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [GAP_W-1:0]         cfg_data,
    output logic                     result_valid,
    output logic                     history_empty,
    output logic [TIME_W-1:0]        time_out,
    output logic [ANG_W-1:0]         pan_out,
    output logic signed [ANG_W-1:0]  tilt_out,
    output logic signed [ANG_W-1:0]  roll_out,
    output logic signed [RATE_W-1:0] pan_rate_out,
    output logic signed [RATE_W-1:0] tilt_rate_out,
    output logic signed [RATE_W-1:0] roll_rate_out,
    output logic                     leveled_out
);

    localparam int AW = 3 * ANG_W + 1;
    localparam int RW = 3 * RATE_W;

    // Sample store: three synchronous memories sharing one address
    logic [TIME_W-1:0] time_mem [HISTORY_DEPTH];
    logic [AW-1:0]     ang_mem  [HISTORY_DEPTH];
    logic [RW-1:0]     rate_mem [HISTORY_DEPTH];

    gti_state_t state_reg, state_next;
    gti_kind_t  kind_reg;

    logic [IDX_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [GAP_W-1:0]  min_gap_reg;

    logic [TIME_W-1:0] query_t_reg;
    logic [CNT_W-1:0]  lo_reg, hi_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [AW-1:0]     rd_ang_reg;
    logic [RW-1:0]     rd_rate_reg;
    logic [TIME_W-1:0] s1_time_reg, s2_time_reg;
    logic [AW-1:0]     s1_ang_reg, s2_ang_reg;
    logic [RW-1:0]     s1_rate_reg, s2_rate_reg;

    logic [TIME_W-1:0] div_d_reg;
    logic [TIME_W:0]   rem_reg;
    logic [ALPHA_W-1:0] q_reg;
    logic [4:0]        step_reg;
    logic signed [ACC_W-1:0] res_reg [LANES];
    logic              result_valid_reg;

    logic              accept, rec_ok;
    logic [IDX_W-1:0]  wr_slot, rd_addr;
    logic [CNT_W-1:0]  mid, lo_new, hi_new, idx2;
    logic              probe_lt;
    logic [TIME_W-1:0] dt_total, dt_target;
    logic [TIME_W:0]   rem_sub;
    logic              rem_ge;
    logic [ALPHA_W-1:0] alpha;
    logic signed [ACC_W-1:0] pan_diff, lane_diff, lane_base, lane_sum, pan_wrap;
    logic signed [ACC_W-1:0] pd0, pd1;
    logic signed [ACC_W+ALPHA_W:0] lane_prod;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign rec_ok    = (count_reg == '0) || (time_us >= last_time_reg);
    assign wr_slot   = (count_reg < CNT_W'(HISTORY_DEPTH)) ? slot_of(oldest_reg, count_reg)
                                                           : oldest_reg;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign probe_lt = rd_time_reg < query_t_reg;
    assign lo_new   = probe_lt ? mid + CNT_W'(1) : lo_reg;
    assign hi_new   = probe_lt ? hi_reg : mid;
    assign idx2     = (lo_reg == count_reg) ? count_reg - CNT_W'(1) : lo_reg;

    assign dt_total  = s2_time_reg - s1_time_reg;
    assign dt_target = query_t_reg - s1_time_reg;
    assign rem_ge    = rem_reg >= {1'b0, div_d_reg};
    assign rem_sub   = rem_ge ? rem_reg - {1'b0, div_d_reg} : rem_reg;
    assign alpha     = (q_reg > ONE_Q16) ? ONE_Q16 : q_reg;

    // Bring the pan difference onto the shortest arc
    always_comb
    begin
        pd0 = ACC_W'($signed({1'b0, s2_ang_reg[ANG_W-1:0]}))
            - ACC_W'($signed({1'b0, s1_ang_reg[ANG_W-1:0]}));
        if (pd0 > HALF_TURN)
            pd1 = pd0 - FULL_TURN;
        else if (pd0 < -HALF_TURN)
            pd1 = pd0 + FULL_TURN;
        else
            pd1 = pd0;
        if (pd1 > HALF_TURN)
            pan_diff = pd1 - FULL_TURN;
        else if (pd1 < -HALF_TURN)
            pan_diff = pd1 + FULL_TURN;
        else
            pan_diff = pd1;
    end

    // Operand select for the shared multiplier lane
    always_comb
    begin
        lane_diff = '0;
        lane_base = '0;
        unique case (step_reg[2:0])
            3'd0:
            begin
                lane_diff = pan_diff;
                lane_base = ACC_W'($signed({1'b0, s1_ang_reg[ANG_W-1:0]}));
            end
            3'd1:
            begin
                lane_base = ACC_W'($signed(s1_ang_reg[2*ANG_W-1:ANG_W]));
                lane_diff = ACC_W'($signed(s2_ang_reg[2*ANG_W-1:ANG_W])) - lane_base;
            end
            3'd2:
            begin
                lane_base = ACC_W'($signed(s1_ang_reg[3*ANG_W-1:2*ANG_W]));
                lane_diff = ACC_W'($signed(s2_ang_reg[3*ANG_W-1:2*ANG_W])) - lane_base;
            end
            3'd3:
            begin
                lane_base = ACC_W'($signed(s1_rate_reg[RATE_W-1:0]));
                lane_diff = ACC_W'($signed(s2_rate_reg[RATE_W-1:0])) - lane_base;
            end
            3'd4:
            begin
                lane_base = ACC_W'($signed(s1_rate_reg[2*RATE_W-1:RATE_W]));
                lane_diff = ACC_W'($signed(s2_rate_reg[2*RATE_W-1:RATE_W])) - lane_base;
            end
            3'd5:
            begin
                lane_base = ACC_W'($signed(s1_rate_reg[3*RATE_W-1:2*RATE_W]));
                lane_diff = ACC_W'($signed(s2_rate_reg[3*RATE_W-1:2*RATE_W])) - lane_base;
            end
            default:
            begin
                lane_diff = '0;
                lane_base = '0;
            end
        endcase
        // floor(alpha * diff / 65536): arithmetic shift floors
        lane_prod = $signed({1'b0, alpha}) * lane_diff;
        lane_sum  = lane_base + ACC_W'(lane_prod >>> 16);
    end

    // Wrap pan into one turn
    always_comb
    begin
        if (res_reg[0] < 0)
            pan_wrap = res_reg[0] + FULL_TURN;
        else if (res_reg[0] >= TWO_TURNS)
            pan_wrap = res_reg[0] - TWO_TURNS;
        else if (res_reg[0] >= FULL_TURN)
            pan_wrap = res_reg[0] - FULL_TURN;
        else
            pan_wrap = res_reg[0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && cmd)
                    state_next = (count_reg == '0) ? ST_EMIT : ST_SRCH_RD;
            ST_SRCH_RD:
                state_next = ST_SRCH_CMP;
            ST_SRCH_CMP:
                state_next = (lo_new == hi_new) ? ST_FETCH2 : ST_SRCH_RD;
            ST_FETCH2:
                state_next = ST_FETCH1;
            ST_FETCH1:
                state_next = (lo_reg == '0 || lo_reg == count_reg) ? ST_EMIT : ST_CAP1;
            ST_CAP1:
                state_next = ST_GAP;
            ST_GAP:
                state_next = (dt_total <= TIME_W'(min_gap_reg)) ? ST_EMIT : ST_DIV;
            ST_DIV:
                if (step_reg == DIV_STEPS - 5'd1)
                    state_next = ST_MUL;
            ST_MUL:
                if (step_reg == MUL_STEPS - 5'd1)
                    state_next = ST_EMIT;
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory address
    always_comb
    begin
        unique case (state_reg)
            ST_FETCH2: rd_addr = slot_of(oldest_reg, idx2);
            ST_FETCH1: rd_addr = slot_of(oldest_reg, lo_reg - CNT_W'(1));
            default:   rd_addr = slot_of(oldest_reg, mid);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cmd && rec_ok)
        begin
            time_mem[wr_slot] <= time_us;
            ang_mem[wr_slot]  <= {leveled_in, roll_in, tilt_in, pan_in};
            rate_mem[wr_slot] <= {roll_rate_in, tilt_rate_in, pan_rate_in};
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_ang_reg  <= ang_mem[rd_addr];
        rd_rate_reg <= rate_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            oldest_reg       <= '0;
            count_reg        <= '0;
            min_gap_reg      <= MIN_GAP_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_EMIT);
            if (cfg_valid && cfg_ready)
                min_gap_reg <= cfg_data;
            if (accept && !cmd && rec_ok)
            begin
                if (count_reg < CNT_W'(HISTORY_DEPTH))
                    count_reg <= count_reg + CNT_W'(1);
                else
                    oldest_reg <= slot_of(oldest_reg, CNT_W'(1));
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !cmd && rec_ok)
                    last_time_reg <= time_us;
                if (accept && cmd)
                begin
                    query_t_reg <= time_us;
                    lo_reg      <= '0;
                    hi_reg      <= count_reg;
                    kind_reg    <= (count_reg == '0) ? OUT_EMPTY : OUT_SAMPLE;
                end
            end
            ST_SRCH_CMP:
            begin
                lo_reg <= lo_new;
                hi_reg <= hi_new;
            end
            ST_FETCH1:
            begin
                s2_time_reg <= rd_time_reg;
                s2_ang_reg  <= rd_ang_reg;
                s2_rate_reg <= rd_rate_reg;
            end
            ST_CAP1:
            begin
                s1_time_reg <= rd_time_reg;
                s1_ang_reg  <= rd_ang_reg;
                s1_rate_reg <= rd_rate_reg;
            end
            ST_GAP:
            begin
                div_d_reg <= dt_total;
                rem_reg   <= {1'b0, dt_target};
                q_reg     <= '0;
                step_reg  <= '0;
                if (dt_total > TIME_W'(min_gap_reg))
                    kind_reg <= OUT_INTERP;
            end
            ST_DIV:
            begin
                q_reg    <= {q_reg[ALPHA_W-2:0], rem_ge};
                rem_reg  <= {rem_sub[TIME_W-1:0], 1'b0};
                step_reg <= (step_reg == DIV_STEPS - 5'd1) ? 5'd0 : step_reg + 5'd1;
            end
            ST_MUL:
            begin
                res_reg[step_reg[2:0]] <= lane_sum;
                step_reg <= step_reg + 5'd1;
            end
            ST_EMIT:
            begin
                unique case (kind_reg)
                    OUT_EMPTY:
                    begin
                        history_empty <= 1'b1;
                        time_out      <= '0;
                        pan_out       <= '0;
                        tilt_out      <= '0;
                        roll_out      <= '0;
                        pan_rate_out  <= '0;
                        tilt_rate_out <= '0;
                        roll_rate_out <= '0;
                        leveled_out   <= 1'b0;
                    end
                    OUT_SAMPLE:
                    begin
                        history_empty <= 1'b0;
                        time_out      <= s2_time_reg;
                        pan_out       <= s2_ang_reg[ANG_W-1:0];
                        tilt_out      <= s2_ang_reg[2*ANG_W-1:ANG_W];
                        roll_out      <= s2_ang_reg[3*ANG_W-1:2*ANG_W];
                        pan_rate_out  <= s2_rate_reg[RATE_W-1:0];
                        tilt_rate_out <= s2_rate_reg[2*RATE_W-1:RATE_W];
                        roll_rate_out <= s2_rate_reg[3*RATE_W-1:2*RATE_W];
                        leveled_out   <= s2_ang_reg[AW-1];
                    end
                    default:
                    begin
                        history_empty <= 1'b0;
                        time_out      <= query_t_reg;
                        pan_out       <= pan_wrap[ANG_W-1:0];
                        tilt_out      <= res_reg[1][ANG_W-1:0];
                        roll_out      <= res_reg[2][ANG_W-1:0];
                        pan_rate_out  <= res_reg[3][RATE_W-1:0];
                        tilt_rate_out <= res_reg[4][RATE_W-1:0];
                        roll_rate_out <= res_reg[5][RATE_W-1:0];
                        leveled_out   <= (alpha >= HALF_Q16) ? s2_ang_reg[AW-1]
                                                             : s1_ang_reg[AW-1];
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("sample count beyond depth");
    a_record_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cmd) |=> !busy)
        else $error("record left block busy");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_result_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result without emit");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import gti_pkg::*;

    // One command as it goes over the start/busy handshake.
    typedef struct {
        logic                     cmd;
        logic [TIME_W-1:0]        t;
        logic [ANG_W-1:0]         pan;
        logic signed [ANG_W-1:0]  tilt;
        logic signed [ANG_W-1:0]  roll;
        logic signed [RATE_W-1:0] pan_rate;
        logic signed [RATE_W-1:0] tilt_rate;
        logic signed [RATE_W-1:0] roll_rate;
        logic                     lev;
    } gimbal_item_t;

    // One query answer as the block shows it.
    typedef struct {
        logic                     empty;
        logic [TIME_W-1:0]        t;
        logic [ANG_W-1:0]         pan;
        logic signed [ANG_W-1:0]  tilt;
        logic signed [ANG_W-1:0]  roll;
        logic signed [RATE_W-1:0] pan_rate;
        logic signed [RATE_W-1:0] tilt_rate;
        logic signed [RATE_W-1:0] roll_rate;
        logic                     lev;
    } pose_result_t;

    localparam int QUIET_LIMIT = 5000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     cmd = 1'b0;
    logic [TIME_W-1:0]        time_us = '0;
    logic [ANG_W-1:0]         pan_in = '0;
    logic signed [ANG_W-1:0]  tilt_in = '0;
    logic signed [ANG_W-1:0]  roll_in = '0;
    logic signed [RATE_W-1:0] pan_rate_in = '0;
    logic signed [RATE_W-1:0] tilt_rate_in = '0;
    logic signed [RATE_W-1:0] roll_rate_in = '0;
    logic                     leveled_in = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [GAP_W-1:0]         cfg_data = '0;
    logic                     result_valid;
    logic                     history_empty;
    logic [TIME_W-1:0]        time_out;
    logic [ANG_W-1:0]         pan_out;
    logic signed [ANG_W-1:0]  tilt_out;
    logic signed [ANG_W-1:0]  roll_out;
    logic signed [RATE_W-1:0] pan_rate_out;
    logic signed [RATE_W-1:0] tilt_rate_out;
    logic signed [RATE_W-1:0] roll_rate_out;
    logic                     leveled_out;

    gimbal_telemetry_time_interpolator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .time_us       (time_us),
        .pan_in        (pan_in),
        .tilt_in       (tilt_in),
        .roll_in       (roll_in),
        .pan_rate_in   (pan_rate_in),
        .tilt_rate_in  (tilt_rate_in),
        .roll_rate_in  (roll_rate_in),
        .leveled_in    (leveled_in),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .history_empty (history_empty),
        .time_out      (time_out),
        .pan_out       (pan_out),
        .tilt_out      (tilt_out),
        .roll_out      (roll_out),
        .pan_rate_out  (pan_rate_out),
        .tilt_rate_out (tilt_rate_out),
        .roll_rate_out (roll_rate_out),
        .leveled_out   (leveled_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the sample ring, kept in logical order (index 0 = oldest).
    gimbal_item_t       history_q[$];
    logic [GAP_W-1:0]   gap_limit_us = MIN_GAP_RESET;
    pose_result_t       expected_poses[$];
    int                 error_count = 0;
    int                 quiet_cycles = 0;
    int                 burst_left = 0;

    // Floor of alpha * (b - a) / 2^16 added to a; arithmetic shift floors.
    function automatic longint blend(longint a, longint b, longint alpha);
        return a + ((alpha * (b - a)) >>> 16);
    endfunction

    function automatic pose_result_t pose_of(gimbal_item_t s);
        pose_result_t r;
        r.empty     = 1'b0;
        r.t         = s.t;
        r.pan       = s.pan;
        r.tilt      = s.tilt;
        r.roll      = s.roll;
        r.pan_rate  = s.pan_rate;
        r.tilt_rate = s.tilt_rate;
        r.roll_rate = s.roll_rate;
        r.lev       = s.lev;
        return r;
    endfunction

    // Append one answer to the outstanding predictions.
    function automatic void expect_pose(pose_result_t r);
        expected_poses.insert(expected_poses.size(), r);
    endfunction

    // Advance the shadow history by one accepted command; queue the answer of a query.
    function automatic void predict_pose(gimbal_item_t it);
        pose_result_t r;
        gimbal_item_t s1, s2;
        int           lo;
        logic [63:0]  span, offset;
        longint       alpha, diff, pan;
        if (it.cmd == 1'b0)
        begin
            // drop out-of-order samples, evict the oldest when full
            if (history_q.size() > 0 && it.t < history_q[$].t)
                return;
            if (history_q.size() == HISTORY_DEPTH)
                history_q.delete(0);
            history_q.insert(history_q.size(), it);
            return;
        end
        if (history_q.size() == 0)
        begin
            r = '{default: '0};
            r.empty = 1'b1;
            expect_pose(r);
            return;
        end
        lo = 0;
        while (lo < history_q.size() && history_q[lo].t < it.t)
            lo++;
        if (lo == 0 || lo == history_q.size())
        begin
            expect_pose(pose_of(history_q[(lo == 0) ? 0 : lo - 1]));
            return;
        end
        s1 = history_q[lo - 1];
        s2 = history_q[lo];
        span = 64'(s2.t - s1.t);
        if (span <= 64'(gap_limit_us))
        begin
            expect_pose(pose_of(s2));
            return;
        end
        offset = 64'(it.t - s1.t);
        alpha  = longint'((offset << 16) / span);
        if (alpha > 65536)
            alpha = 65536;
        diff = longint'(s2.pan) - longint'(s1.pan);
        while (diff > 18000)
            diff -= 36000;
        while (diff < -18000)
            diff += 36000;
        pan = longint'(s1.pan) + ((alpha * diff) >>> 16);
        pan = pan % 36000;
        if (pan < 0)
            pan += 36000;
        r.empty     = 1'b0;
        r.t         = it.t;
        r.pan       = ANG_W'(pan);
        r.tilt      = ANG_W'(blend(s1.tilt, s2.tilt, alpha));
        r.roll      = ANG_W'(blend(s1.roll, s2.roll, alpha));
        r.pan_rate  = RATE_W'(blend(s1.pan_rate, s2.pan_rate, alpha));
        r.tilt_rate = RATE_W'(blend(s1.tilt_rate, s2.tilt_rate, alpha));
        r.roll_rate = RATE_W'(blend(s1.roll_rate, s2.roll_rate, alpha));
        r.lev       = (alpha >= 32768) ? s2.lev : s1.lev;
        expect_pose(r);
    endfunction

    // Hold the item on the ports until an edge sees start high and busy low.
    // Call at a rising edge; return at the edge that takes the item, start left high.
    task automatic send_item(gimbal_item_t it);
        start        <= 1'b1;
        cmd          <= it.cmd;
        time_us      <= it.t;
        pan_in       <= it.pan;
        tilt_in      <= it.tilt;
        roll_in      <= it.roll;
        pan_rate_in  <= it.pan_rate;
        tilt_rate_in <= it.tilt_rate;
        roll_rate_in <= it.roll_rate;
        leveled_in   <= it.lev;
        do
            @(posedge clk);
        while (busy);
        predict_pose(it);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender bursts: random run length, with chance three in four a random gap before a new run.
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 10));
        end
        burst_left--;
    endtask

    // Wait until every answer is in and the block is idle, plus a few cycles for
    // a record that yields nothing.
    task automatic drain();
        pause(1);
        while (expected_poses.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gap_limit(logic [GAP_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        gap_limit_us = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic gimbal_item_t make_record(logic [TIME_W-1:0] t, bit wild);
        gimbal_item_t it;
        it.cmd = 1'b0;
        it.t   = t;
        if (wild)
        begin
            // full bit patterns, well outside the nominal ranges
            it.pan       = ANG_W'($urandom);
            it.tilt      = ANG_W'($urandom);
            it.roll      = ANG_W'($urandom);
            it.pan_rate  = RATE_W'($urandom);
            it.tilt_rate = RATE_W'($urandom);
            it.roll_rate = RATE_W'($urandom);
        end
        else
        begin
            it.pan       = ANG_W'($urandom_range(0, 35999));
            it.tilt      = ANG_W'(int'($urandom_range(0, 36000)) - 18000);
            it.roll      = ANG_W'(int'($urandom_range(0, 36000)) - 18000);
            it.pan_rate  = RATE_W'(int'($urandom_range(0, 200000)) - 100000);
            it.tilt_rate = RATE_W'(int'($urandom_range(0, 200000)) - 100000);
            it.roll_rate = RATE_W'(int'($urandom_range(0, 200000)) - 100000);
        end
        it.lev = 1'($urandom);
        return it;
    endfunction

    function automatic gimbal_item_t make_query(logic [TIME_W-1:0] t);
        gimbal_item_t it;
        it     = '{default: '0};
        it.cmd = 1'b1;
        it.t   = t;
        // unused fields still toggle
        it.pan  = ANG_W'($urandom);
        it.lev  = 1'($urandom);
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] newest_time();
        return (history_q.size() == 0) ? '0 : history_q[$].t;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each answer with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        pose_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_poses.size() == 0)
            begin
                $error("result with nothing outstanding");
                error_count++;
            end
            else
            begin
                want = expected_poses[0];
                expected_poses.delete(0);
                check_field("history_empty", want.empty, history_empty);
                check_field("time_out", want.t, time_out);
                check_field("pan_out", want.pan, pan_out);
                check_field("tilt_out", 64'(unsigned'(want.tilt)), 64'(unsigned'(tilt_out)));
                check_field("roll_out", 64'(unsigned'(want.roll)), 64'(unsigned'(roll_out)));
                check_field("pan_rate_out", 64'(unsigned'(want.pan_rate)),
                            64'(unsigned'(pan_rate_out)));
                check_field("tilt_rate_out", 64'(unsigned'(want.tilt_rate)),
                            64'(unsigned'(tilt_rate_out)));
                check_field("roll_rate_out", 64'(unsigned'(want.roll_rate)),
                            64'(unsigned'(roll_rate_out)));
                check_field("leveled_out", want.lev, leveled_out);
            end
        end
    end

    // Watchdog: end the run after too long without any handshake.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_empty_query();
        send_item(make_query('0));
        send_item(make_query('1));
    endtask

    // Edges of the history: before first, after last, small gap, blend, pan wrap.
    task automatic test_edge_cases();
        gimbal_item_t it;
        it = make_record(48'd1000, 0);
        it.pan = 16'd35900;
        it.tilt = -16'sd18000;
        it.roll = 16'sd18000;
        it.pan_rate = -18'sd100000;
        it.tilt_rate = 18'sd100000;
        it.roll_rate = -18'sd100000;
        it.lev = 1'b0;
        send_item(it);
        send_item(make_query(48'd0));
        send_item(make_query(48'd5000));
        it = make_record(48'd2000, 0);
        it.pan = 16'd100;                       // shortest arc crosses zero
        it.tilt = 16'sd18000;
        it.roll = -16'sd18000;
        it.pan_rate = 18'sd100000;
        it.tilt_rate = -18'sd100000;
        it.roll_rate = 18'sd100000;
        it.lev = 1'b1;
        send_item(it);
        send_item(make_query(48'd1001));
        send_item(make_query(48'd1499));
        send_item(make_query(48'd1500));
        send_item(make_query(48'd1999));
        send_item(make_query(48'd2000));
        send_item(make_record(48'd2050, 0));    // spacing below the gap limit
        send_item(make_query(48'd2020));
        send_item(make_record(48'd1500, 0));    // out of order: dropped
        send_item(make_record(48'd2050, 0));    // equal time is kept
        send_item(make_query(48'd2050));
        send_item(make_record(48'd4000, 1));    // out-of-range values
        send_item(make_record(48'd9000, 1));
        send_item(make_query(48'd6000));
        send_item(make_query(48'd8999));
        send_item(make_query(48'd9001));
    endtask

    task automatic test_gap_register();
        write_gap_limit('0);
        send_item(make_record(newest_time() + 1, 0));
        send_item(make_record(newest_time() + 1, 0));
        send_item(make_query(newest_time()));
        write_gap_limit('1);
        send_item(make_record(newest_time() + 1048575, 0));
        send_item(make_query(newest_time() - 10));
        send_item(make_record(newest_time() + 1048576, 0));
        send_item(make_query(newest_time() - 1000));
        write_gap_limit(GAP_W'(100));
    endtask

    // Mostly well-formed sample streams with queries inside the kept window.
    task automatic test_random_traffic(int count);
        logic [TIME_W-1:0] lo_t, hi_t, t;
        int                pick;
        repeat (count)
        begin
            pace();
            pick = $urandom_range(0, 99);
            if (history_q.size() != 0)
            begin
                lo_t = history_q[0].t;
                hi_t = history_q[$].t;
            end
            else
            begin
                lo_t = '0;
                hi_t = '0;
            end
            if (pick < 45)
                send_item(make_record(hi_t + $urandom_range(0, 400), pick < 4));
            else if (pick < 50)
                send_item(make_record(hi_t - $urandom_range(1, 500), 0));
            else if (pick < 90)
            begin
                t = lo_t + ((hi_t - lo_t) * $urandom_range(0, 1000)) / 1000;
                send_item(make_query(t + $urandom_range(0, 3) - 1));
            end
            else if (pick < 95)
                send_item(make_query(lo_t - $urandom_range(0, 50)));
            else
                send_item(make_query(TIME_W'({$urandom, $urandom})));
        end
    endtask

    task automatic test_gap_sweep();
        write_gap_limit(GAP_W'(0));
        test_random_traffic(120);
        write_gap_limit(GAP_W'(250));
        test_random_traffic(120);
        write_gap_limit(GAP_W'(1000000));
        test_random_traffic(40);
        write_gap_limit(GAP_W'(37));
        test_random_traffic(120);
    endtask

    // Drive the top bits of time: records in the upper half of the 48-bit range.
    task automatic test_time_extremes();
        send_item(make_record(48'h8000_0000_0000 | ($urandom & 24'hFF_FFFF), 0));
        send_item(make_record(48'hAAAA_5555_AAAA, 0));
        send_item(make_record(48'hFFFF_FFFF_0000, 0));
        send_item(make_query(48'hD555_AAAA_5555));
        send_item(make_record(48'hFFFF_FFFF_FFFF, 0));
        send_item(make_query(48'hFFFF_FFFF_8000));
        send_item(make_query(48'hFFFF_FFFF_FFFF));
        send_item(make_query(48'h7FFF_FFFF_FFFF));
        send_item(make_record(48'h0, 0));        // far out of order
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_query();
        test_edge_cases();
        test_gap_register();
        test_random_traffic(260);
        test_gap_sweep();
        test_time_extremes();
        drain();
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_poses.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
